// ===== rtl/pds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  // Loop order of the modulator and bits per output word.
  localparam int Order    = 7;
  localparam int WordBits = 32;
  localparam int MaxRatio = 64;

  localparam int StepW   = $clog2(Order);
  localparam int BitCntW = $clog2(WordBits);
  localparam int RatioW  = $clog2(MaxRatio + 1);

  // Field widths of the ports.
  localparam int SampleW = 24;
  localparam int OutW    = 32;
  localparam int CfgW    = 7;
  localparam int IntW    = 32;

  localparam logic [CfgW-1:0] RatioReset = CfgW'(8);

  // 0.707 in Q0.16, kept as a positive signed constant.
  localparam logic signed [16:0] GainQ16 = 17'sd46334;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StEmit
  } pds_state_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [StepW-1:0] idx;
  } pds_ctrl_t;

  // Feedback weights in Q.24, one per integrator.
  function automatic logic signed [IntW-1:0] coef_q24(input logic [StepW-1:0] k);
    logic signed [IntW-1:0] c;
    c = '0;
    case (k)
      3'd0:    c = 32'sd168;
      3'd1:    c = 32'sd1342;
      3'd2:    c = 32'sd10066;
      3'd3:    c = 32'sd83886;
      3'd4:    c = 32'sd671089;
      3'd5:    c = 32'sd2516582;
      3'd6:    c = 32'sd8388608;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pds_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pds_lane (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire pds_pkg::pds_ctrl_t                 ctrl_i,
  input  wire logic signed [pds_pkg::SampleW-1:0] sample_i,
  output logic [pds_pkg::WordBits-1:0]            word_o
);
  import pds_pkg::*;

  localparam int ProdW = SampleW + 17;
  localparam int XW    = ProdW - 15;
  localparam int SumW  = IntW + 2;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] rounded;
  logic signed [XW-1:0]    x_d, x_q;

  logic signed [IntW-1:0]  int_q [Order];
  logic signed [IntW-1:0]  prev_q;
  logic signed [IntW-1:0]  cur;
  logic signed [IntW-1:0]  prev;
  logic signed [IntW-1:0]  coef;
  logic signed [IntW-1:0]  fb_term;
  logic signed [SumW-1:0]  sum;
  logic signed [IntW-1:0]  sat;
  logic                    fb_pos;
  logic                    last_step;
  logic [WordBits-1:0]     word_q;

  // Scale by 0.707 with round half up, Q.39 down to Q.24.
  assign prod    = ProdW'(sample_i) * ProdW'(GainQ16);
  assign rounded = prod + ProdW'(16384);
  assign x_d     = rounded[ProdW-1:15];

  // The last integrator is not rewritten before the final step of a bit, so its
  // current value is the sign that set this bit's feedback.
  assign fb_pos    = int_q[Order-1] > 0;
  assign last_step = ctrl_i.idx == StepW'(Order - 1);

  always_comb begin
    cur     = int_q[ctrl_i.idx];
    prev    = (ctrl_i.idx == '0) ? IntW'(x_q) : prev_q;
    coef    = coef_q24(ctrl_i.idx);
    fb_term = fb_pos ? -coef : coef;
    sum     = SumW'(cur) + SumW'(prev) + SumW'(fb_term);
    if (sum[SumW-1:IntW-1] == '0 || sum[SumW-1:IntW-1] == '1) begin
      sat = sum[IntW-1:0];
    end else if (sum[SumW-1]) begin
      sat = {1'b1, {(IntW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(IntW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Order; i++) begin
        int_q[i] <= '0;
      end
    end else if (ctrl_i.step) begin
      int_q[ctrl_i.idx] <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= x_d;
    end
    if (ctrl_i.step) begin
      prev_q <= sat;
      if (last_step) begin
        word_q <= {word_q[WordBits-2:0], sat > 0};
      end
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// ===== rtl/pcm_to_dsd_sigma_delta_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stereo PCM to DSD converter. Each accepted frame of two Q1.23 samples is
// scaled by 0.707 and fed to one seventh-order sigma-delta modulator per
// channel, and the frame yields oversample_ratio word pairs of 32 DSD bits
// (earliest bit in the MSB), the final pair flagged by last_of_frame_o. A
// ratio of zero acts as one and values above 64 act as 64; the reset ratio is
// 8. Each channel has one saturating adder that, while a word is being built,
// updates one integrator per cycle, so each DSD bit steps through all seven
// integrators in turn; after each word the block hands the pair to the output
// register, waiting while that register is still held by out_stall_i. Input
// stall is low only while the block is idle. The ratio register is written
// through the configuration port, which is always ready, and should only be
// written while no frame is in progress.

module pcm_to_dsd_sigma_delta_unit (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pds_pkg::CfgW-1:0]           cfg_data_i,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [pds_pkg::SampleW-1:0] left_sample_i,
  input  wire logic signed [pds_pkg::SampleW-1:0] right_sample_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic [pds_pkg::OutW-1:0]                left_bits_o,
  output logic [pds_pkg::OutW-1:0]                right_bits_o,
  output logic                                    last_of_frame_o
);
  import pds_pkg::*;

  pds_state_e state_d, state_q;

  logic [CfgW-1:0]     cfg_q;
  logic [RatioW-1:0]   ratio_eff;
  logic [RatioW-1:0]   words_left_q;
  logic [StepW-1:0]    step_q;
  logic [BitCntW-1:0]  bit_cnt_q;
  logic                in_accept;
  logic                word_done;
  logic                load_out;
  logic                last_word;
  pds_ctrl_t           ctrl;
  logic [WordBits-1:0] left_word, right_word;

  logic                out_valid_q;
  logic [OutW-1:0]     left_bits_q, right_bits_q;
  logic                last_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != StIdle;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign last_word   = words_left_q == RatioW'(1);
  assign word_done   = state_q == StRun && step_q == StepW'(Order - 1)
                       && bit_cnt_q == BitCntW'(WordBits - 1);

  always_comb begin
    if (cfg_q == '0) begin
      ratio_eff = RatioW'(1);
    end else if (32'(cfg_q) > MaxRatio) begin
      ratio_eff = RatioW'(MaxRatio);
    end else begin
      ratio_eff = RatioW'(cfg_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (word_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = last_word ? StIdle : StRun;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    ctrl.idx  = step_q;
    load_out  = 1'b0;
    case (state_q)
      StIdle:  ctrl.load = in_accept;
      StRun:   ctrl.step = 1'b1;
      StEmit:  load_out  = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cfg_q        <= RatioReset;
      words_left_q <= '0;
      step_q       <= '0;
      bit_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (in_accept) begin
        words_left_q <= ratio_eff;
        step_q       <= '0;
        bit_cnt_q    <= '0;
      end else if (ctrl.step) begin
        if (step_q == StepW'(Order - 1)) begin
          step_q    <= '0;
          bit_cnt_q <= (bit_cnt_q == BitCntW'(WordBits - 1)) ? '0 : bit_cnt_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (load_out) begin
        words_left_q <= words_left_q - 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      left_bits_q  <= OutW'(left_word);
      right_bits_q <= OutW'(right_word);
      last_q       <= last_word;
    end
  end

  pds_lane u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (left_sample_i),
    .word_o   (left_word)
  );

  pds_lane u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (right_sample_i),
    .word_o   (right_word)
  );

  assign out_valid_o     = out_valid_q;
  assign left_bits_o     = left_bits_q;
  assign right_bits_o    = right_bits_q;
  assign last_of_frame_o = last_q;

  // A new word pair never overwrites a result that is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  // While a frame is in progress at least one word pair remains to be sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (words_left_q != '0))
    else $error("frame in progress with no words left");

  // The step index never leaves the integrator chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepW'(Order - 1))
    else $error("step index out of range");

  // Once a frame is taken, no other frame is taken in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after frame transfer");

  // The flagged pair ends the frame, so the block is idle right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last_word) |=> (state_q == StIdle))
    else $error("block busy after last word pair");

endmodule

`default_nettype wire
